@@ sv/mpk_pkg.sv @@
// mpk_pkg: shared widths, constants and controller/datapath command types
// for the k-transaction max profit block. No dependencies.
package mpk_pkg;

  localparam int PRICE_W  = 16;
  localparam int HOLD_W   = 34;
  localparam int FREE_W   = 33;
  localparam int PROFIT_W = 31;
  localparam int CFG_W    = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd2;

  // controller -> datapath commands for one cycle
  typedef struct packed {
    logic load;      // latch price and open flag of the accepted word
    logic rd_en;     // read both tables at rd_addr
    logic step;      // update entry wr_addr from the read data
    logic first;     // entry being updated is count 0
    logic hit_k;     // entry being updated is the reported count
    logic out_load;  // move the result into the output register
  } mpk_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
  } mpk_sts_t;

endpackage

@@ sv/mpk_ctrl.sv @@
// mpk_ctrl: sequencer for the per-price sweep over all transaction counts,
// plus the max_transactions register. Depends on mpk_pkg.
module mpk_ctrl #(
  parameter int MAX_K = 16,
  parameter int IW    = $clog2(MAX_K + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic                       in_start,
  input  logic                       cfg_we,
  input  logic [mpk_pkg::CFG_W-1:0]  cfg_wdata,
  input  mpk_pkg::mpk_sts_t          sts,
  output mpk_pkg::mpk_cmd_t          cmd,
  output logic                       open_item,
  output logic [IW-1:0]              rd_addr,
  output logic [IW-1:0]              wr_addr
);
  import mpk_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_K);

  state_t            state_r, state_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [IW-1:0]     k_r, k_nxt;
  logic [CFG_W-1:0]  cfg_r;
  logic              series_open_r;
  logic              accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign open_item = in_start || !series_open_r;
  assign wr_addr   = idx_r;

  always_comb begin
    if (32'(cfg_r) > MAX_K) begin
      k_nxt = LAST_IDX;
    end else begin
      k_nxt = IW'(cfg_r);
    end
  end

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    cmd          = '0;
    rd_addr      = idx_r + IW'(1);
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.load  = 1'b1;
          cmd.rd_en = 1'b1;
          rd_addr   = '0;
          idx_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.step  = 1'b1;
        cmd.first = (idx_r == '0);
        cmd.hit_k = (idx_r == k_r);
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.rd_en = 1'b1;
          idx_nxt   = idx_r + IW'(1);
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      idx_r         <= '0;
      cfg_r         <= CFG_RESET;
      series_open_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (accept) begin
        series_open_r <= 1'b1;
      end
    end
  end

  // k is frozen per word
  always_ff @(posedge clk) begin
    if (accept) begin
      k_r <= k_nxt;
    end
  end

`ifndef SYNTH
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (32'(idx_r) <= MAX_K))
    else $error("sweep index past last entry");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_RUN && idx_r == '0))
    else $error("accepted word did not start sweep at entry 0");

  a_sweep_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && idx_r == LAST_IDX) |=> (state_r == ST_FIN))
    else $error("sweep did not finish after last entry");

  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded into a full output register");
`endif

endmodule

@@ sv/mpk_dp.sv @@
// mpk_dp: holding/free tables, per-entry update, result capture, saturation
// and output register. Depends on mpk_pkg.
module mpk_dp #(
  parameter int MAX_K = 16,
  parameter int IW    = $clog2(MAX_K + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mpk_pkg::mpk_cmd_t             cmd,
  output mpk_pkg::mpk_sts_t             sts,
  input  logic                          open_item,
  input  logic [IW-1:0]                 rd_addr,
  input  logic [IW-1:0]                 wr_addr,
  input  logic [mpk_pkg::PRICE_W-1:0]   in_price,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mpk_pkg::PROFIT_W-1:0]  out_profit
);
  import mpk_pkg::*;

  localparam int SW = HOLD_W + 1;

  logic signed [HOLD_W-1:0] hold_mem [0:MAX_K];
  logic signed [FREE_W-1:0] free_mem [0:MAX_K];

  logic [PRICE_W-1:0]       price_r;
  logic                     open_r;
  logic signed [HOLD_W-1:0] hold_rd_r;
  logic signed [FREE_W-1:0] free_rd_r;
  logic signed [HOLD_W-1:0] prev_hold_r;   // old hold of the previous count
  logic signed [FREE_W-1:0] res_r;
  logic [PROFIT_W-1:0]      out_data_r;
  logic                     out_valid_r;

  logic signed [SW-1:0] p_x, hold_x, free_x, prev_x;
  logic signed [SW-1:0] buy_v, sell_v, h_v, f_v;
  logic [PROFIT_W-1:0]  sat_v;

  assign p_x    = $signed({{(SW-PRICE_W){1'b0}}, price_r});
  assign hold_x = $signed({{(SW-HOLD_W){hold_rd_r[HOLD_W-1]}}, hold_rd_r});
  assign free_x = $signed({{(SW-FREE_W){free_rd_r[FREE_W-1]}}, free_rd_r});
  assign prev_x = $signed({{(SW-HOLD_W){prev_hold_r[HOLD_W-1]}}, prev_hold_r});
  assign buy_v  = free_x - p_x;
  assign sell_v = prev_x + p_x;

  always_comb begin
    if (open_r) begin
      h_v = -p_x;
      f_v = '0;
    end else if (cmd.first) begin
      h_v = (hold_x > -p_x) ? hold_x : -p_x;
      f_v = '0;
    end else begin
      h_v = (hold_x > buy_v) ? hold_x : buy_v;
      f_v = (free_x > sell_v) ? free_x : sell_v;
    end
  end

  // clamp to 0 .. 2^31-1
  always_comb begin
    if (res_r[FREE_W-1]) begin
      sat_v = '0;
    end else if (res_r[FREE_W-2]) begin
      sat_v = '1;
    end else begin
      sat_v = res_r[PROFIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      hold_mem[wr_addr] <= h_v[HOLD_W-1:0];
      free_mem[wr_addr] <= f_v[FREE_W-1:0];
    end
    if (cmd.rd_en) begin
      hold_rd_r <= hold_mem[rd_addr];
      free_rd_r <= free_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      price_r <= in_price;
      open_r  <= open_item;
    end
    if (cmd.step) begin
      prev_hold_r <= hold_rd_r;
    end
    if (cmd.step && cmd.hit_k) begin
      res_r <= f_v[FREE_W-1:0];
    end
    if (cmd.out_load) begin
      out_data_r <= sat_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_profit   = out_data_r;

endmodule

@@ sv/max_profit_k_transactions_top.sv @@
// Each price word goes through a load step, a sweep over table entries 0..MAX_K and a hand-off
//   into the output register. in_tready is high only while idle, so no new price is taken until
//   the previous result has been handed off; the hand-off waits while the output register is full.
// Reset (rst_n, synchronous, active low): idle, output empty, max_transactions = 2,
//   no series open. Tables are not cleared; the first word always opens a series.
module max_profit_k_transactions_top #(
  parameter int MAX_K = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] price
  input  logic        in_tuser,    // [0] start_series
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [30:0] best_profit, [31] zero
  // max_transactions write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data     // [4:0] max_transactions
);
  import mpk_pkg::*;

  localparam int IW = $clog2(MAX_K + 1);

  mpk_cmd_t            cmd;
  mpk_sts_t            sts;
  logic                open_item;
  logic [IW-1:0]       rd_addr;
  logic [IW-1:0]       wr_addr;
  logic [PROFIT_W-1:0] profit;

  // register writes always taken; only legal while idle anyway
  assign cfg_ready = 1'b1;

  // controller: sequences load, sweep of counts 0..MAX_K, result hand-off
  mpk_ctrl #(
    .MAX_K (MAX_K),
    .IW    (IW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_start  (in_tuser),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_wdata (cfg_data),
    .sts       (sts),
    .cmd       (cmd),
    .open_item (open_item),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr)
  );

  // datapath: tables, max-of-buy/sell update, saturation, output register
  mpk_dp #(
    .MAX_K (MAX_K),
    .IW    (IW)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .open_item  (open_item),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .in_price   (in_tdata[PRICE_W-1:0]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_profit (profit)
  );

  assign out_tdata = {1'b0, profit};

endmodule

@@ sim/max_profit_checker.sv @@
// max_profit_checker: watches the price, result and max_transactions channels of
// max_profit_k_transactions_top, predicts each best_profit word and compares.
// Depends on mpk_pkg for the field widths and the register reset value.
`timescale 1ns / 100ps

module max_profit_checker #(
  parameter int MAX_K = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [mpk_pkg::PRICE_W-1:0] in_tdata,   // [15:0] price
  input  logic                        in_tuser,   // [0] start_series
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [31:0]                 out_tdata,  // [30:0] best_profit, [31] zero
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [mpk_pkg::CFG_W-1:0]   cfg_data,   // [4:0] max_transactions
  output int                          mismatches,
  output int                          profits_due
);
  import mpk_pkg::*;

  logic [CFG_W-1:0]          trade_limit;
  logic signed [HOLD_W-1:0]  long_best [0:MAX_K];  // best value holding a share
  logic signed [FREE_W-1:0]  flat_best [0:MAX_K];  // best value holding none
  logic                      series_live;
  logic [PROFIT_W-1:0]       profit_queue [$];
  int                        fail_count = 0;

  // one day of the DP; returns the clamped profit at the active count
  function automatic logic [PROFIT_W-1:0] trade_day(logic [PRICE_W-1:0] price,
                                                    logic opens);
    longint p;
    longint h;
    longint f;
    longint r;
    int     k;
    p = longint'(price);
    k = (trade_limit > MAX_K) ? MAX_K : int'(trade_limit);
    if (opens || !series_live) begin
      for (int j = 0; j <= MAX_K; j++) begin
        long_best[j] = HOLD_W'(-p);
        flat_best[j] = '0;
      end
      series_live = 1'b1;
    end else begin
      // high counts first so long_best[j-1] is still yesterday's value
      for (int j = MAX_K; j >= 1; j--) begin
        h = longint'(long_best[j]);
        if (longint'(flat_best[j]) - p > h) h = longint'(flat_best[j]) - p;
        f = longint'(flat_best[j]);
        if (longint'(long_best[j-1]) + p > f) f = longint'(long_best[j-1]) + p;
        long_best[j] = HOLD_W'(h);
        flat_best[j] = FREE_W'(f);
      end
      if (-p > longint'(long_best[0])) long_best[0] = HOLD_W'(-p);
      flat_best[0] = '0;
    end
    r = longint'(flat_best[k]);
    if (r < 0) r = 0;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    return r[PROFIT_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic [PROFIT_W-1:0] want;
    if (!rst_n) begin
      trade_limit = CFG_RESET;
      series_live = 1'b0;
      profit_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) trade_limit = cfg_data;
      if (in_tvalid && in_tready)
        profit_queue.push_back(trade_day(in_tdata, in_tuser));
      if (out_tvalid && out_tready) begin
        if (profit_queue.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %0d",
                   $time, out_tdata);
          fail_count++;
        end else begin
          want = profit_queue.pop_front();
          if (out_tdata !== {1'b0, want}) begin
            $display("%0t: best_profit mismatch, expected %0d, actual %0d",
                     $time, {1'b0, want}, out_tdata);
            fail_count++;
          end
        end
      end
    end
    mismatches  <= fail_count;
    profits_due <= profit_queue.size();
  end

endmodule

@@ sim/tb.sv @@
// tb: stimulus and verdict for max_profit_k_transactions_top.
// Needs mpk_pkg, the block's RTL and max_profit_checker, which does the
// prediction and comparison; this module only drives the channels.
`timescale 1ns / 100ps

module tb;
  import mpk_pkg::*;

  localparam int MAX_K       = 16;
  localparam int PHASE_WORDS = 410;  // random price words per idling phase

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [PRICE_W-1:0]  in_tdata = '0;
  logic                in_tuser = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [31:0]         out_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_data = '0;

  int mismatches;
  int profits_due;
  int tx_idle = 0;     // percent of cycles the price sender holds off
  int rx_idle = 0;     // percent of cycles the result receiver stalls
  int words_sent = 0;

  max_profit_k_transactions_top #(.MAX_K(MAX_K)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  max_profit_checker #(.MAX_K(MAX_K)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .profits_due (profits_due)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result side: random stalls at the rate of the current phase.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_idle);
  end

  // Run limit, far beyond the slowest legal run.
  initial begin
    #(10_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  // One price word. tvalid is left high after the handshake; the next call
  // (or drain_results) sets it in the same step, so it is never dropped and
  // raised again within one step.
  task automatic send_word(input logic [PRICE_W-1:0] price, input logic opens);
    while ($urandom_range(0, 99) < tx_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= price;
    in_tuser  <= opens;
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  // Stop sending and wait until every predicted word has come back.
  // profits_due is registered in the checker, hence the do-while.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (profits_due != 0);
  endtask

  // max_transactions is only written with the block idle.
  task automatic set_trade_limit(input logic [CFG_W-1:0] k);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= k;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // A random series: uniform prices, a random walk (where multi-trade
  // profits build up) or swings between the extremes. Most series open with
  // the start flag; some carry on the previous one, a few restart midway.
  task automatic run_series();
    int   len;
    int   mode;
    int   price;
    logic opens;
    len   = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 24);
    mode  = $urandom_range(0, 3);
    price = $urandom_range(0, 65535);
    for (int i = 0; i < len; i++) begin
      if (i > 0) begin
        case (mode) inside
          0: price = $urandom_range(0, 65535);
          [1:2]: begin
            price = price + int'($urandom_range(0, 8000)) - 4000;
            if (price < 0) price = 0;
            if (price > 65535) price = 65535;
          end
          default: price = $urandom_range(0, 1) ? 65535 : $urandom_range(0, 15);
        endcase
      end
      opens = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
      send_word(price[PRICE_W-1:0], opens);
    end
  endtask

  initial begin
    int words_goal;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle = 17;
    rx_idle = 61;

    // Directed words. First word after reset opens a series without the flag;
    // default k = 2 gives two full swings.
    send_word(16'hFFFF, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'hFFFF, 1'b0);
    // zero transactions, series kept open across the write
    set_trade_limit(5'd0);
    send_word(16'h0000, 1'b0);
    send_word(16'hFFFF, 1'b0);
    // count above MAX_K behaves as MAX_K; restart flag in mid series
    set_trade_limit(5'd31);
    send_word(16'hAAAA, 1'b0);
    send_word(16'h5555, 1'b1);
    send_word(16'hAAAA, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'hFFFF, 1'b0);
    // full count with saw-tooth prices
    set_trade_limit(5'd16);
    send_word(16'h0000, 1'b1);
    for (int i = 0; i < 3; i++) begin
      send_word(16'hFFFF, 1'b0);
      send_word(16'h0000, 1'b0);
    end
    send_word(16'hFFFF, 1'b0);
    // count lowered in mid series takes effect at once
    set_trade_limit(5'd1);
    send_word(16'hFFFF, 1'b0);

    // Random part in three idling phases: sender light / receiver heavy,
    // the reverse, then no idling at all.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin tx_idle = 17; rx_idle = 61; end
        1: begin tx_idle = 61; rx_idle = 17; end
        default: begin tx_idle = 0; rx_idle = 0; end
      endcase
      words_goal = words_sent + PHASE_WORDS;
      while (words_sent < words_goal) begin
        if ($urandom_range(0, 2) == 0) begin
          case ($urandom_range(0, 6))
            0: set_trade_limit(5'd0);
            1: set_trade_limit(5'd16);
            2: set_trade_limit(5'd31);
            3: set_trade_limit(5'd17);
            4: set_trade_limit(5'd1);
            default: set_trade_limit(CFG_W'($urandom_range(0, 31)));
          endcase
        end
        run_series();
      end
    end

    drain_results();
    repeat (MAX_K + 8) @(posedge clk);
    if (mismatches == 0 && profits_due == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
